>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the verification files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is asserted.
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Holds in the cycle after every clock edge with reset asserted.
`define PBA_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("post-reset check failed");

`endif

>>> sv/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the packed bitfield array modules.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 15;
  localparam int VALUE_W  = 31;
  localparam int CFG_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 22;   // bit position plus element width, with headroom
  localparam int WIDX_W   = 16;   // word index of the lower word of an element
  localparam int WORD_W   = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT     = 16'd32768;
  localparam logic [CFG_W-1:0]   WIDTH_DEFAULT = 5'd8;

  localparam int IN_DATA_W  = 48;  // index + value, padded to whole bytes
  localparam int OUT_DATA_W = 48;  // read_value + element_count, padded

  localparam int Q_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR  = 2'd3
  } pba_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } pba_status_e;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_READ  = 2'd1,
    K_WRITE = 2'd2
  } pba_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } pba_bstate_e;

  // One classified request, passed from the front end to the back end.
  typedef struct packed {
    pba_kind_e           kind;
    logic [WIDX_W-1:0]   word_idx;
    logic [4:0]          offset;
    logic [CFG_W-1:0]    width;
    logic                straddle;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    pba_status_e         status;
  } pba_cmd_t;

endpackage

>>> sv/pba_front.sv
// ----------------------------------------------------------------------------
// pba_front
// Accepts requests, owns the element count and width register, checks the
// index and computes the bit position of the element.
// ----------------------------------------------------------------------------
module pba_front import pba_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output pba_cmd_t            q_cmd
);

  localparam logic [POS_W-1:0] STORE_BITS = POS_W'(STORE_WORDS * WORD_W);

  logic [CFG_W-1:0]   width_r, width_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  pba_op_e            op;
  logic [CFG_W-1:0]   w_eff;
  logic [COUNT_W-1:0] pos_idx;
  logic [POS_W-2:0]   bit_pos;
  logic [POS_W-1:0]   bit_end;
  logic               fits;
  logic [WORD_W-1:0]  mask32;
  logic               accept;

  assign op        = pba_op_e'(in_op);
  assign w_eff     = (width_r == '0) ? CFG_W'(1) : width_r;
  assign pos_idx   = (op == OP_APPEND) ? count_r : {1'b0, in_index};
  assign bit_pos   = (POS_W-1)'(pos_idx) * (POS_W-1)'(w_eff);
  assign bit_end   = {1'b0, bit_pos} + POS_W'(w_eff);
  assign fits      = (bit_end <= STORE_BITS);
  assign mask32    = (WORD_W'(1) << w_eff) - WORD_W'(1);
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;
  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt = cfg_valid ? cfg_data : width_r;
    count_nxt = count_r;

    q_cmd.kind     = K_NONE;
    q_cmd.word_idx = bit_pos[5 +: WIDX_W];
    q_cmd.offset   = bit_pos[4:0];
    q_cmd.width    = w_eff;
    q_cmd.straddle = ({1'b0, bit_pos[4:0]} + {1'b0, w_eff}) > 6'd32;
    q_cmd.value    = in_value & mask32[VALUE_W-1:0];
    q_cmd.status   = ST_OK;

    unique case (op)
      OP_READ, OP_WRITE: begin
        if (({1'b0, in_index} < count_r) && fits) begin
          q_cmd.kind = (op == OP_READ) ? K_READ : K_WRITE;
        end else begin
          q_cmd.status = ST_BAD_INDEX;
        end
      end
      OP_APPEND: begin
        if ((count_r < MAX_COUNT) && fits) begin
          q_cmd.kind = K_WRITE;
          count_nxt  = count_r + COUNT_W'(1);
        end else begin
          q_cmd.status = ST_FULL;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        q_cmd.kind = K_NONE;
      end
    endcase

    q_cmd.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_DEFAULT;
      count_r <= '0;
    end else begin
      width_r <= width_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

>>> sv/pba_cmd_queue.sv
// ----------------------------------------------------------------------------
// pba_cmd_queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module pba_cmd_queue import pba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pba_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output pba_cmd_t head
);

  localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  pba_cmd_t           mem_r [Q_DEPTH];
  logic [QPW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]       fill_r, fill_nxt;

  assign full      = (fill_r == (QPW+1)'(Q_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (QPW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/pba_back.sv
// ----------------------------------------------------------------------------
// pba_back
// Carries out requests on two word banks (even and odd words): it reads both
// words an element may touch, then extracts or merges and writes back. Holds
// the result register.
// ----------------------------------------------------------------------------
module pba_back import pba_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  pba_cmd_t              q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int BANK_DEPTH = STORE_WORDS / 2 + 1;
  localparam int BAW        = $clog2(BANK_DEPTH);

  logic [WORD_W-1:0] even_mem [BANK_DEPTH];
  logic [WORD_W-1:0] odd_mem  [BANK_DEPTH];

  pba_bstate_e state_r, state_nxt;
  pba_cmd_t    cur_r;
  logic [WORD_W-1:0] even_q_r, odd_q_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [WIDX_W:0]   head_p1, cur_p1;
  logic [BAW-1:0]    head_even_addr, head_odd_addr;
  logic [BAW-1:0]    cur_even_addr, cur_odd_addr;
  logic              lo_odd;
  logic [WORD_W-1:0] lo_word, hi_word;
  logic [63:0]       pair, mask64, new_pair;
  logic [WORD_W-1:0] mask32;
  logic [VALUE_W-1:0] rd_val;
  logic [WORD_W-1:0] even_wdata, odd_wdata;
  logic              even_we, odd_we;
  logic              finish;

  // The lower word of an element sits in the bank chosen by its index parity.
  assign head_p1        = {1'b0, q_head.word_idx} + (WIDX_W+1)'(1);
  assign head_even_addr = BAW'(head_p1 >> 1);
  assign head_odd_addr  = BAW'(q_head.word_idx >> 1);
  assign cur_p1         = {1'b0, cur_r.word_idx} + (WIDX_W+1)'(1);
  assign cur_even_addr  = BAW'(cur_p1 >> 1);
  assign cur_odd_addr   = BAW'(cur_r.word_idx >> 1);

  assign lo_odd   = cur_r.word_idx[0];
  assign lo_word  = lo_odd ? odd_q_r : even_q_r;
  assign hi_word  = lo_odd ? even_q_r : odd_q_r;
  assign pair     = {hi_word, lo_word};
  assign mask32   = (WORD_W'(1) << cur_r.width) - WORD_W'(1);
  assign mask64   = {32'd0, mask32} << cur_r.offset;
  assign new_pair = (pair & ~mask64) | ({33'd0, cur_r.value} << cur_r.offset);
  assign rd_val   = VALUE_W'(pair >> cur_r.offset) & mask32[VALUE_W-1:0];

  assign even_wdata = lo_odd ? new_pair[63:32] : new_pair[31:0];
  assign odd_wdata  = lo_odd ? new_pair[31:0] : new_pair[63:32];

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    finish        = 1'b0;
    even_we       = 1'b0;
    odd_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_r || out_ready) begin
          finish        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
          if (cur_r.kind == K_WRITE) begin
            even_we = !lo_odd || cur_r.straddle;
            odd_we  = lo_odd || cur_r.straddle;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (finish) begin
      out_data_r   <= {1'b0, cur_r.count,
                       (cur_r.kind == K_READ) ? rd_val : VALUE_W'(0)};
      out_status_r <= cur_r.status;
    end
  end

  // Word banks: registered reads at issue, writes at completion.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      even_q_r <= even_mem[head_even_addr];
    end
    if (even_we) begin
      even_mem[cur_even_addr] <= even_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      odd_q_r <= odd_mem[head_odd_addr];
    end
    if (odd_we) begin
      odd_mem[cur_odd_addr] <= odd_wdata;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

endmodule

>>> sv/packed_bitfield_array_top.sv
// ----------------------------------------------------------------------------
// packed_bitfield_array_top
// Array of unsigned elements of configurable width packed into 32-bit words.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream channel: in_tuser carries the operation
// (read, write, append, clear count), in_tdata the index and the value.
// Each request produces exactly one transfer on the out_ channel with the
// element read (zero unless a successful read), the element count after the
// request and a status code (ok, bad index, store full).
// The element width is set over the cfg_ channel; a value of zero acts as
// one bit. Change it only while no request is in flight.
// When the channel is idle, a request passes through the request queue, the
// bank read at issue and the result register before its result is offered.
// The back end works on one request at a time: it reads both word banks,
// then extracts or merges and writes back. A two-entry request queue lets
// the front end keep taking requests while the back end works or the result
// waits. When the receiver stalls, the result register holds and the back
// end waits; once the queue fills, in_tready drops.
// Reset clears the count, the width (to eight bits) and all handshake state;
// memory contents are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
module packed_bitfield_array_top import pba_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [14:0] index, [45:15] value, [47:46] zero
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] op
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [30:0] read_value, [46:31] element_count,
                                            // [47] zero
  output logic [STATUS_W-1:0]   out_tuser,  // [1:0] status
  // Element width register.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  pba_cmd_t push_cmd, head_cmd;
  logic     q_push, q_pop, q_full, q_not_empty;

  // The front end classifies each request against the current count and
  // width, so the count seen by the next request is always up to date.
  pba_front #(.STORE_WORDS(STORE_WORDS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_index  (in_tdata[INDEX_W-1:0]),
    .in_value  (in_tdata[INDEX_W +: VALUE_W]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pba_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  // The back end runs one request at a time, so a write always lands before
  // the next request reads the banks.
  pba_back #(.STORE_WORDS(STORE_WORDS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_status  (out_tuser)
  );

endmodule

>>> sv/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the packed bitfield array, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pba_checker import pba_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // A refused request never returns element data.
  `PBA_ASSERT_IMPLY(a_err_no_data, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata[VALUE_W-1:0] == '0)

  // The reported count never goes past the element limit.
  `PBA_ASSERT_IMPLY(a_count_limit, clk, rst_n, out_tvalid, out_tdata[VALUE_W +: COUNT_W] <= MAX_COUNT)

  // A stalled result holds its contents until taken.
  `PBA_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // No result is offered in the cycle after a reset.
  `PBA_ASSERT_AFTER_RESET(a_reset_quiet, clk, rst_n, !out_tvalid)

endmodule

bind packed_bitfield_array_top pba_checker u_pba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
